FILE: hw/rtl/dmfp_pkg.sv
package dmfp_pkg;

    // one message byte as it arrives from the link
    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_message;
    } dmfp_in_t;

    // one decoded field
    typedef struct packed {
        logic [3:0]  field_kind;
        logic [31:0] field_value;
        logic [2:0]  section;
        logic        query_response;
        logic [3:0]  op_code;
        logic        authoritative;
        logic        truncated;
        logic        recursion_desired;
        logic        recursion_available;
        logic [2:0]  reserved_bits;
        logic [3:0]  response_code;
        logic        message_done;
    } dmfp_out_t;

    // parse phase
    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_LENGTH = 3'd1,
        PH_LABEL  = 3'd2,
        PH_TYPE   = 3'd3,
        PH_CLASS  = 3'd4,
        PH_TTL    = 3'd5,
        PH_RDLEN  = 3'd6,
        PH_RDATA  = 3'd7
    } phase_t;

    // field kinds
    localparam logic [3:0] KIND_ID        = 4'd0;
    localparam logic [3:0] KIND_FLAGS     = 4'd1;
    localparam logic [3:0] KIND_QDCOUNT   = 4'd2;
    localparam logic [3:0] KIND_ANCOUNT   = 4'd3;
    localparam logic [3:0] KIND_NSCOUNT   = 4'd4;
    localparam logic [3:0] KIND_ARCOUNT   = 4'd5;
    localparam logic [3:0] KIND_NAME_CHAR = 4'd6;
    localparam logic [3:0] KIND_NAME_END  = 4'd7;
    localparam logic [3:0] KIND_TYPE      = 4'd8;
    localparam logic [3:0] KIND_CLASS     = 4'd9;
    localparam logic [3:0] KIND_TTL       = 4'd10;
    localparam logic [3:0] KIND_RDLENGTH  = 4'd11;
    localparam logic [3:0] KIND_RDATA     = 4'd12;
    localparam logic [3:0] KIND_ERROR     = 4'd13;

    // sections
    localparam logic [2:0] SEC_HEADER     = 3'd0;
    localparam logic [2:0] SEC_QUESTION   = 3'd1;
    localparam logic [2:0] SEC_ANSWER     = 3'd2;
    localparam logic [2:0] SEC_AUTHORITY  = 3'd3;
    localparam logic [2:0] SEC_ADDITIONAL = 3'd4;

    // error codes
    localparam logic [31:0] ERR_POINTER   = 32'd1;
    localparam logic [31:0] ERR_LABEL_LEN = 32'd2;
    localparam logic [31:0] ERR_NAME_LEN  = 32'd3;

    // characters
    localparam logic [7:0] CHAR_DOT     = 8'h2E;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;
    localparam logic [7:0] MAX_LABEL    = 8'd63;

endpackage

FILE: hw/rtl/dmfp_in_stage.sv
module dmfp_in_stage
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  dmfp_pkg::dmfp_in_t in_data,
    input  logic               take,
    output logic               hold_valid,
    output dmfp_pkg::dmfp_in_t hold_data
);

    logic               valid_reg;
    logic               valid_next;
    dmfp_pkg::dmfp_in_t data_reg;

    // refill in the same cycle the held beat is consumed
    assign in_ready   = !valid_reg || take;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= in_data;
        end
    end

    assign hold_valid = valid_reg;
    assign hold_data  = data_reg;

endmodule

FILE: hw/rtl/dmfp_out_stage.sv
module dmfp_out_stage
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  dmfp_pkg::dmfp_out_t res,
    output logic                free,
    output logic                out_valid,
    input  logic                out_ready,
    output dmfp_pkg::dmfp_out_t out_data
);

    logic                valid_reg;
    logic                valid_next;
    dmfp_pkg::dmfp_out_t data_reg;

    assign free       = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: hw/rtl/dmfp_parse_core.sv
module dmfp_parse_core
#(
    parameter int unsigned MAX_NAME_LEN = 255
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  dmfp_pkg::dmfp_in_t  item,
    input  logic                fold_case,
    output logic                res_valid,
    output dmfp_pkg::dmfp_out_t res
);

    localparam logic [9:0] NAME_LIMIT = 10'(MAX_NAME_LEN);

    dmfp_pkg::phase_t phase_reg, phase_next;
    logic [3:0]  hdr_off_reg, hdr_off_next;
    logic [2:0]  bytes_seen_reg, bytes_seen_next;
    logic [31:0] shift_reg, shift_next;
    logic [15:0] qd_left_reg, qd_left_next;
    logic [15:0] an_left_reg, an_left_next;
    logic [15:0] ns_left_reg, ns_left_next;
    logic [15:0] ar_left_reg, ar_left_next;
    logic [5:0]  label_left_reg, label_left_next;
    logic [7:0]  name_len_reg, name_len_next;
    logic        first_label_reg, first_label_next;
    logic [15:0] rdata_left_reg, rdata_left_next;
    logic [2:0]  section_reg, section_next;
    logic        is_resp_reg, is_resp_next;
    logic        done_reg, done_next;

    logic [7:0]  b;
    logic        start;
    logic        live;

    // header decode
    logic [15:0] hdr_word;
    logic [3:0]  hdr_kind;
    logic [15:0] hdr_ar;
    logic [2:0]  hdr_ns;
    logic        hdr_finish;
    logic        hdr_stop;

    // name decode
    logic        err_ptr;
    logic        err_len;
    logic [9:0]  name_need;
    logic        err_name;
    logic [7:0]  name_char;

    // fixed-size fields
    logic [2:0]  fld_last;
    logic        fld_complete;
    logic [31:0] fld_value;
    logic        end_fld;
    logic        end_rd;
    logic        end_rec;

    // record end bookkeeping
    logic [15:0] qd_dec, an_dec, ns_dec, ar_dec;
    logic [2:0]  er_ns;
    logic        er_last;

    assign b     = item.data_byte;
    assign start = item.start_of_message;
    assign live  = step && !start && !done_reg;

    assign hdr_word   = {shift_reg[7:0], b};
    assign hdr_kind   = {1'b0, hdr_off_reg[3:1]};
    assign hdr_ar     = (hdr_kind == dmfp_pkg::KIND_ARCOUNT) ? hdr_word : ar_left_reg;
    assign hdr_finish = hdr_kind >= dmfp_pkg::KIND_ARCOUNT;
    assign hdr_stop   = is_resp_reg || (hdr_ns == dmfp_pkg::SEC_HEADER);

    always_comb
    begin
        priority if (qd_left_reg != 16'd0)
            hdr_ns = dmfp_pkg::SEC_QUESTION;
        else if (an_left_reg != 16'd0)
            hdr_ns = dmfp_pkg::SEC_ANSWER;
        else if (ns_left_reg != 16'd0)
            hdr_ns = dmfp_pkg::SEC_AUTHORITY;
        else if (hdr_ar != 16'd0)
            hdr_ns = dmfp_pkg::SEC_ADDITIONAL;
        else
            hdr_ns = dmfp_pkg::SEC_HEADER;
    end

    assign err_ptr   = (b[7:6] == 2'b11);
    assign err_len   = b > dmfp_pkg::MAX_LABEL;
    assign name_need = {2'b00, name_len_reg} + {9'd0, !first_label_reg} + {2'b00, b};
    assign err_name  = name_need > NAME_LIMIT;
    assign name_char = (fold_case && b >= dmfp_pkg::CHAR_UPPER_A && b <= dmfp_pkg::CHAR_UPPER_Z)
                       ? b + dmfp_pkg::CASE_OFFSET : b;

    assign fld_last     = (phase_reg == dmfp_pkg::PH_TTL) ? 3'd3 : 3'd1;
    assign fld_complete = (bytes_seen_reg == fld_last);
    assign fld_value    = {shift_reg[23:0], b};
    assign end_fld = fld_complete &&
                     (((phase_reg == dmfp_pkg::PH_CLASS) && (section_reg == dmfp_pkg::SEC_QUESTION))
                      || ((phase_reg == dmfp_pkg::PH_RDLEN) && (fld_value[15:0] == 16'd0)));
    assign end_rd  = (phase_reg == dmfp_pkg::PH_RDATA) && (rdata_left_reg == 16'd1);
    assign end_rec = end_fld || end_rd;

    // the finished record comes off its own section count
    assign qd_dec = (section_reg == dmfp_pkg::SEC_QUESTION && qd_left_reg != 16'd0)
                    ? qd_left_reg - 16'd1 : qd_left_reg;
    assign an_dec = (section_reg == dmfp_pkg::SEC_ANSWER && an_left_reg != 16'd0)
                    ? an_left_reg - 16'd1 : an_left_reg;
    assign ns_dec = (section_reg == dmfp_pkg::SEC_AUTHORITY && ns_left_reg != 16'd0)
                    ? ns_left_reg - 16'd1 : ns_left_reg;
    assign ar_dec = (section_reg == dmfp_pkg::SEC_ADDITIONAL && ar_left_reg != 16'd0)
                    ? ar_left_reg - 16'd1 : ar_left_reg;

    // first section from the current one on with a record left
    always_comb
    begin
        priority if (section_reg <= dmfp_pkg::SEC_QUESTION && qd_dec != 16'd0)
            er_ns = dmfp_pkg::SEC_QUESTION;
        else if (section_reg <= dmfp_pkg::SEC_ANSWER && an_dec != 16'd0)
            er_ns = dmfp_pkg::SEC_ANSWER;
        else if (section_reg <= dmfp_pkg::SEC_AUTHORITY && ns_dec != 16'd0)
            er_ns = dmfp_pkg::SEC_AUTHORITY;
        else if (section_reg <= dmfp_pkg::SEC_ADDITIONAL && ar_dec != 16'd0)
            er_ns = dmfp_pkg::SEC_ADDITIONAL;
        else
            er_ns = dmfp_pkg::SEC_HEADER;
    end

    assign er_last = (er_ns == dmfp_pkg::SEC_HEADER);

    // next state
    always_comb
    begin
        phase_next       = phase_reg;
        hdr_off_next     = hdr_off_reg;
        bytes_seen_next  = bytes_seen_reg;
        shift_next       = shift_reg;
        qd_left_next     = qd_left_reg;
        an_left_next     = an_left_reg;
        ns_left_next     = ns_left_reg;
        ar_left_next     = ar_left_reg;
        label_left_next  = label_left_reg;
        name_len_next    = name_len_reg;
        first_label_next = first_label_reg;
        rdata_left_next  = rdata_left_reg;
        section_next     = section_reg;
        is_resp_next     = is_resp_reg;
        done_next        = done_reg;

        if (step && start)
        begin
            // fresh message, this beat is header byte 0
            phase_next       = dmfp_pkg::PH_HEADER;
            hdr_off_next     = 4'd1;
            bytes_seen_next  = 3'd0;
            shift_next       = {24'd0, b};
            qd_left_next     = 16'd0;
            an_left_next     = 16'd0;
            ns_left_next     = 16'd0;
            ar_left_next     = 16'd0;
            label_left_next  = 6'd0;
            name_len_next    = 8'd0;
            first_label_next = 1'b1;
            rdata_left_next  = 16'd0;
            section_next     = dmfp_pkg::SEC_HEADER;
            is_resp_next     = 1'b0;
            done_next        = 1'b0;
        end
        else if (live)
        begin
            unique case (phase_reg)
                dmfp_pkg::PH_HEADER:
                begin
                    hdr_off_next = hdr_off_reg + 4'd1;
                    if (!hdr_off_reg[0])
                    begin
                        shift_next = {24'd0, b};
                    end
                    else
                    begin
                        shift_next = {16'd0, hdr_word};
                        unique case (hdr_kind)
                            dmfp_pkg::KIND_FLAGS:   is_resp_next = hdr_word[15];
                            dmfp_pkg::KIND_QDCOUNT: qd_left_next = hdr_word;
                            dmfp_pkg::KIND_ANCOUNT: an_left_next = hdr_word;
                            dmfp_pkg::KIND_NSCOUNT: ns_left_next = hdr_word;
                            dmfp_pkg::KIND_ARCOUNT: ar_left_next = hdr_word;
                            default: ;
                        endcase
                        if (hdr_finish)
                        begin
                            if (hdr_stop)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                section_next     = hdr_ns;
                                phase_next       = dmfp_pkg::PH_LENGTH;
                                first_label_next = 1'b1;
                                name_len_next    = 8'd0;
                                label_left_next  = 6'd0;
                            end
                        end
                    end
                end
                dmfp_pkg::PH_LENGTH:
                begin
                    priority if (b == 8'd0)
                    begin
                        phase_next      = dmfp_pkg::PH_TYPE;
                        bytes_seen_next = 3'd0;
                        shift_next      = 32'd0;
                    end
                    else if (err_ptr || err_len || err_name)
                    begin
                        done_next = 1'b1;
                    end
                    else
                    begin
                        label_left_next = b[5:0];
                        phase_next      = dmfp_pkg::PH_LABEL;
                        if (first_label_reg)
                            first_label_next = 1'b0;
                        else
                            name_len_next = name_len_reg + 8'd1;
                    end
                end
                dmfp_pkg::PH_LABEL:
                begin
                    name_len_next   = name_len_reg + 8'd1;
                    label_left_next = label_left_reg - 6'd1;
                    if (label_left_reg == 6'd1)
                        phase_next = dmfp_pkg::PH_LENGTH;
                end
                dmfp_pkg::PH_TYPE, dmfp_pkg::PH_CLASS, dmfp_pkg::PH_TTL, dmfp_pkg::PH_RDLEN:
                begin
                    shift_next      = fld_value;
                    bytes_seen_next = bytes_seen_reg + 3'd1;
                    if (fld_complete)
                    begin
                        bytes_seen_next = 3'd0;
                        shift_next      = 32'd0;
                        if (!end_fld)
                        begin
                            unique case (phase_reg)
                                dmfp_pkg::PH_TYPE:  phase_next = dmfp_pkg::PH_CLASS;
                                dmfp_pkg::PH_CLASS: phase_next = dmfp_pkg::PH_TTL;
                                dmfp_pkg::PH_TTL:   phase_next = dmfp_pkg::PH_RDLEN;
                                default:            phase_next = dmfp_pkg::PH_RDATA;
                            endcase
                        end
                        if (phase_reg == dmfp_pkg::PH_RDLEN)
                            rdata_left_next = fld_value[15:0];
                    end
                end
                dmfp_pkg::PH_RDATA:
                begin
                    rdata_left_next = rdata_left_reg - 16'd1;
                end
            endcase

            if (end_rec && phase_reg != dmfp_pkg::PH_HEADER
                && phase_reg != dmfp_pkg::PH_LENGTH && phase_reg != dmfp_pkg::PH_LABEL)
            begin
                qd_left_next = qd_dec;
                an_left_next = an_dec;
                ns_left_next = ns_dec;
                ar_left_next = ar_dec;
                if (er_last)
                begin
                    done_next = 1'b1;
                end
                else
                begin
                    section_next     = er_ns;
                    phase_next       = dmfp_pkg::PH_LENGTH;
                    first_label_next = 1'b1;
                    name_len_next    = 8'd0;
                    label_left_next  = 6'd0;
                end
            end
        end
    end

    // result
    always_comb
    begin
        res_valid = 1'b0;
        res       = '0;
        if (live)
        begin
            unique case (phase_reg)
                dmfp_pkg::PH_HEADER:
                begin
                    if (hdr_off_reg[0])
                    begin
                        res_valid         = 1'b1;
                        res.field_kind    = hdr_kind;
                        res.field_value   = {16'd0, hdr_word};
                        res.section       = dmfp_pkg::SEC_HEADER;
                        res.message_done  = hdr_finish && hdr_stop;
                        if (hdr_kind == dmfp_pkg::KIND_FLAGS)
                        begin
                            res.query_response      = hdr_word[15];
                            res.op_code             = hdr_word[14:11];
                            res.authoritative       = hdr_word[10];
                            res.truncated           = hdr_word[9];
                            res.recursion_desired   = hdr_word[8];
                            res.recursion_available = hdr_word[7];
                            res.reserved_bits       = hdr_word[6:4];
                            res.response_code       = hdr_word[3:0];
                        end
                    end
                end
                dmfp_pkg::PH_LENGTH:
                begin
                    res.section = section_reg;
                    priority if (b == 8'd0)
                    begin
                        res_valid       = 1'b1;
                        res.field_kind  = dmfp_pkg::KIND_NAME_END;
                        res.field_value = {24'd0, name_len_reg};
                    end
                    else if (err_ptr)
                    begin
                        res_valid        = 1'b1;
                        res.field_kind   = dmfp_pkg::KIND_ERROR;
                        res.field_value  = dmfp_pkg::ERR_POINTER;
                        res.message_done = 1'b1;
                    end
                    else if (err_len)
                    begin
                        res_valid        = 1'b1;
                        res.field_kind   = dmfp_pkg::KIND_ERROR;
                        res.field_value  = dmfp_pkg::ERR_LABEL_LEN;
                        res.message_done = 1'b1;
                    end
                    else if (err_name)
                    begin
                        res_valid        = 1'b1;
                        res.field_kind   = dmfp_pkg::KIND_ERROR;
                        res.field_value  = dmfp_pkg::ERR_NAME_LEN;
                        res.message_done = 1'b1;
                    end
                    else if (!first_label_reg)
                    begin
                        res_valid       = 1'b1;
                        res.field_kind  = dmfp_pkg::KIND_NAME_CHAR;
                        res.field_value = {24'd0, dmfp_pkg::CHAR_DOT};
                    end
                end
                dmfp_pkg::PH_LABEL:
                begin
                    res_valid       = 1'b1;
                    res.field_kind  = dmfp_pkg::KIND_NAME_CHAR;
                    res.field_value = {24'd0, name_char};
                    res.section     = section_reg;
                end
                dmfp_pkg::PH_TYPE, dmfp_pkg::PH_CLASS, dmfp_pkg::PH_TTL, dmfp_pkg::PH_RDLEN:
                begin
                    if (fld_complete)
                    begin
                        res_valid = 1'b1;
                        unique case (phase_reg)
                            dmfp_pkg::PH_TYPE:  res.field_kind = dmfp_pkg::KIND_TYPE;
                            dmfp_pkg::PH_CLASS: res.field_kind = dmfp_pkg::KIND_CLASS;
                            dmfp_pkg::PH_TTL:   res.field_kind = dmfp_pkg::KIND_TTL;
                            default:            res.field_kind = dmfp_pkg::KIND_RDLENGTH;
                        endcase
                        res.field_value  = fld_value;
                        // a record that hands over reports the section it hands over to
                        res.section      = (end_fld && !er_last) ? er_ns : section_reg;
                        res.message_done = end_fld && er_last;
                    end
                end
                dmfp_pkg::PH_RDATA:
                begin
                    res_valid        = 1'b1;
                    res.field_kind   = dmfp_pkg::KIND_RDATA;
                    res.field_value  = {24'd0, b};
                    res.section      = section_reg;
                    res.message_done = end_rd && er_last;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= dmfp_pkg::PH_HEADER;
            hdr_off_reg     <= 4'd0;
            bytes_seen_reg  <= 3'd0;
            shift_reg       <= 32'd0;
            qd_left_reg     <= 16'd0;
            an_left_reg     <= 16'd0;
            ns_left_reg     <= 16'd0;
            ar_left_reg     <= 16'd0;
            label_left_reg  <= 6'd0;
            name_len_reg    <= 8'd0;
            first_label_reg <= 1'b1;
            rdata_left_reg  <= 16'd0;
            section_reg     <= dmfp_pkg::SEC_HEADER;
            is_resp_reg     <= 1'b0;
            done_reg        <= 1'b1;
        end
        else
        begin
            phase_reg       <= phase_next;
            hdr_off_reg     <= hdr_off_next;
            bytes_seen_reg  <= bytes_seen_next;
            shift_reg       <= shift_next;
            qd_left_reg     <= qd_left_next;
            an_left_reg     <= an_left_next;
            ns_left_reg     <= ns_left_next;
            ar_left_reg     <= ar_left_next;
            label_left_reg  <= label_left_next;
            name_len_reg    <= name_len_next;
            first_label_reg <= first_label_next;
            rdata_left_reg  <= rdata_left_next;
            section_reg     <= section_next;
            is_resp_reg     <= is_resp_next;
            done_reg        <= done_next;
        end
    end

endmodule

FILE: hw/rtl/dns_message_field_parser.sv
// DNS message field parser. Message bytes arrive in wire order, one per input beat, with
// start_of_message set on the first byte of each message; a start beat always abandons
// whatever message was in progress. The 12-byte header comes out as id, flags (split into
// its bit fields) and the four section counts. For a query the parser then walks the
// question, answer, authority and additional records, giving each name one character per
// beat with dots between labels, then type, class (where a question record ends), ttl,
// rdlength and the rdata bytes; a response stops after arcount. message_done marks the
// last field of a message and every error (compression pointer, label longer than 63, name
// longer than MAX_NAME_LEN); after that the parser ignores bytes until the next start beat.
// fold_case (reset 1) lowercases name characters; the user must write it only while the
// parser is idle, not enforced by the block. Throughput is one byte per clock whenever
// the result side keeps taking beats: each byte passes an input register, decode against
// the parse state and a result register. Bytes that complete no field produce no beat.
module dns_message_field_parser
#(
    parameter int unsigned MAX_NAME_LEN = 255
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  dmfp_pkg::dmfp_in_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output dmfp_pkg::dmfp_out_t out_data,
    input  logic                cfg_wr_en,
    input  logic                cfg_wr_data
);

    logic                fold_case_reg;
    logic                fold_case_next;

    logic                hold_valid;
    dmfp_pkg::dmfp_in_t  hold_data;
    logic                out_free;
    logic                fire;
    logic                res_valid;
    dmfp_pkg::dmfp_out_t res;

    // configuration register, no read-back
    assign fold_case_next = cfg_wr_en ? cfg_wr_data : fold_case_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fold_case_reg <= 1'b1;
        end
        else
        begin
            fold_case_reg <= fold_case_next;
        end
    end

    // held byte is decoded once the result register can take whatever it yields
    assign fire = hold_valid && out_free;

    dmfp_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .take       (fire),
        .hold_valid (hold_valid),
        .hold_data  (hold_data)
    );

    // parse state and per-byte decode
    dmfp_parse_core
    #(
        .MAX_NAME_LEN (MAX_NAME_LEN)
    )
    u_parse_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (fire),
        .item      (hold_data),
        .fold_case (fold_case_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // result register, decouples the two sides
    dmfp_out_stage u_out_stage
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire && res_valid),
        .res       (res),
        .free      (out_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
